// File: sv/rvp_pkg.sv
// ----------------------------------------------------------------------------
// rvp_pkg
// Shared types and codes of the record body varint parser: byte roles,
// error codes and the result structure that travels from the parse stage
// to the result register.
// ----------------------------------------------------------------------------
package rvp_pkg;

   // Byte roles reported with every result.
   localparam logic [3:0] ROLE_KEYLEN   = 4'd0;
   localparam logic [3:0] ROLE_KEY      = 4'd1;
   localparam logic [3:0] ROLE_VALLEN   = 4'd2;
   localparam logic [3:0] ROLE_VALUE    = 4'd3;
   localparam logic [3:0] ROLE_HDRCOUNT = 4'd4;
   localparam logic [3:0] ROLE_HKEYLEN  = 4'd5;
   localparam logic [3:0] ROLE_HKEY     = 4'd6;
   localparam logic [3:0] ROLE_HVALLEN  = 4'd7;
   localparam logic [3:0] ROLE_HVALUE   = 4'd8;
   localparam logic [3:0] ROLE_IGNORED  = 4'd9;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_LONG      = 2'd1;
   localparam logic [1:0] ERR_TRUNC     = 2'd2;
   localparam logic [1:0] ERR_CAPACITY  = 2'd3;

   // Width of the varint byte counter.
   localparam int VCNT_W = 4;

   // Width of the output packing.
   localparam int RSP_DATA_W = 112;

   // One result item.
   typedef struct packed {
      logic [7:0]         byte_out;
      logic [3:0]         role;
      logic               field_end;
      logic               field_null;
      logic signed [63:0] length_value;
      logic [31:0]        header_number;
      logic               record_done;
      logic [1:0]         fault_code;
   } result_type;

endpackage

// File: sv/rvp_parser.sv
// ----------------------------------------------------------------------------
// rvp_parser
// Parser state and the per-byte update. The result for the presented byte
// is formed combinationally from the current state; the state advances when
// the byte is stepped.
// ----------------------------------------------------------------------------
module rvp_parser #(
   parameter int LEN_BITS         = 32,
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output rvp_pkg::result_type result
);
   import rvp_pkg::*;

   // Parse phases, one-hot.
   typedef enum logic [9:0] {
      PH_KEYLEN   = 10'b0000000001,
      PH_KEY      = 10'b0000000010,
      PH_VALLEN   = 10'b0000000100,
      PH_VALUE    = 10'b0000001000,
      PH_HDRCOUNT = 10'b0000010000,
      PH_HKEYLEN  = 10'b0000100000,
      PH_HKEY     = 10'b0001000000,
      PH_HVALLEN  = 10'b0010000000,
      PH_HVALUE   = 10'b0100000000,
      PH_IDLE     = 10'b1000000000
   } phase_type;

   // Role code of a phase.
   function automatic logic [3:0] phase_role(input phase_type ph);
      logic [3:0] r;
      unique case (ph)
         PH_KEYLEN:   r = ROLE_KEYLEN;
         PH_KEY:      r = ROLE_KEY;
         PH_VALLEN:   r = ROLE_VALLEN;
         PH_VALUE:    r = ROLE_VALUE;
         PH_HDRCOUNT: r = ROLE_HDRCOUNT;
         PH_HKEYLEN:  r = ROLE_HKEYLEN;
         PH_HKEY:     r = ROLE_HKEY;
         PH_HVALLEN:  r = ROLE_HVALLEN;
         PH_HVALUE:   r = ROLE_HVALUE;
         default:     r = ROLE_IGNORED;
      endcase
      return r;
   endfunction

   // Data phase that follows a length phase.
   function automatic phase_type data_phase_of(input phase_type ph);
      phase_type d;
      unique case (ph)
         PH_KEYLEN:  d = PH_KEY;
         PH_VALLEN:  d = PH_VALUE;
         PH_HKEYLEN: d = PH_HKEY;
         PH_HVALLEN: d = PH_HVALUE;
         default:    d = PH_IDLE;
      endcase
      return d;
   endfunction

   // State registers.
   phase_type           phase_ff, phase_in;
   logic [63:0]         acc_ff, acc_in;
   logic [VCNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic [LEN_BITS-1:0] hdr_left_ff, hdr_left_in;
   logic [LEN_BITS-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic                err_ff, err_in;

   // Per-byte working signals.
   logic                active;
   logic                in_data;
   logic                in_header;
   logic [LEN_BITS-1:0] left_dec;
   logic [5:0]          shamt;
   logic [63:0]         acc_new;
   logic [63:0]         zz;
   logic                neg;
   logic                over;
   logic                leave;
   phase_type           leave_ph;
   logic [63:0]         hc_wide;

   always_comb begin
      in_data   = (phase_ff == PH_KEY) || (phase_ff == PH_VALUE) ||
                  (phase_ff == PH_HKEY) || (phase_ff == PH_HVALUE);
      in_header = (phase_ff == PH_HKEYLEN) || (phase_ff == PH_HKEY) ||
                  (phase_ff == PH_HVALLEN) || (phase_ff == PH_HVALUE);
      active    = !err_ff && (phase_ff != PH_IDLE);
      left_dec  = left_ff - LEN_BITS'(1);
      shamt     = 6'({2'b00, cnt_ff} * 6'd7);
      acc_new   = acc_ff | ({57'd0, data_byte[6:0]} << shamt);
      zz        = (acc_new >> 1) ^ {64{acc_new[0]}};
      neg       = zz[63];
      over      = !neg && ((zz >> LEN_BITS) != 64'd0);
      hc_wide   = 64'(hdr_cnt_ff);
   end

   // Next state and result for the presented byte.
   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      left_in     = left_ff;
      hdr_left_in = hdr_left_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      err_in      = err_ff;
      leave       = 1'b0;
      leave_ph    = PH_IDLE;

      result               = '0;
      result.byte_out      = data_byte;
      result.role          = ROLE_IGNORED;
      result.fault_code    = ERR_NONE;

      if (active) begin
         result.role = phase_role(phase_ff);
         if (in_header) begin
            result.header_number = hc_wide[31:0];
         end
         if (in_data) begin
            // Count down the field data.
            left_in = left_dec;
            if (left_dec == '0) begin
               result.field_end = 1'b1;
               leave            = 1'b1;
               leave_ph         = phase_ff;
            end
         end else if (cnt_ff >= VCNT_W'(MAX_VARINT_BYTES)) begin
            result.fault_code = ERR_LONG;
            err_in            = 1'b1;
         end else begin
            // Accumulate seven payload bits per varint byte.
            acc_in = acc_new;
            cnt_in = cnt_ff + VCNT_W'(1);
            if (!data_byte[7]) begin
               acc_in              = '0;
               cnt_in              = '0;
               result.field_end    = 1'b1;
               result.length_value = zz;
               if (over) begin
                  result.fault_code = ERR_CAPACITY;
                  err_in            = 1'b1;
               end else if (phase_ff == PH_HDRCOUNT) begin
                  if (neg || zz == 64'd0) begin
                     phase_in           = PH_IDLE;
                     result.record_done = 1'b1;
                  end else begin
                     hdr_left_in = zz[LEN_BITS-1:0];
                     hdr_cnt_in  = '0;
                     phase_in    = PH_HKEYLEN;
                  end
               end else begin
                  // A null header key is reported as an empty one.
                  result.field_null = neg && (phase_ff != PH_HKEYLEN);
                  if (neg || zz == 64'd0) begin
                     leave    = 1'b1;
                     leave_ph = data_phase_of(phase_ff);
                  end else begin
                     left_in  = zz[LEN_BITS-1:0];
                     phase_in = data_phase_of(phase_ff);
                  end
               end
            end
         end

         // Move past a finished data field.
         if (leave) begin
            case (leave_ph)
               PH_KEY:   phase_in = PH_VALLEN;
               PH_VALUE: phase_in = PH_HDRCOUNT;
               PH_HKEY:  phase_in = PH_HVALLEN;
               default: begin
                  hdr_cnt_in  = hdr_cnt_ff + LEN_BITS'(1);
                  hdr_left_in = hdr_left_ff - LEN_BITS'(1);
                  if (hdr_left_ff == LEN_BITS'(1)) begin
                     phase_in           = PH_IDLE;
                     result.record_done = 1'b1;
                  end else begin
                     phase_in = PH_HKEYLEN;
                  end
               end
            endcase
         end

         // Payload ended inside the record.
         if (last_byte && result.fault_code == ERR_NONE && phase_in != PH_IDLE) begin
            result.fault_code = ERR_TRUNC;
            err_in            = 1'b1;
         end
      end

      // The last byte re-arms the parser.
      if (last_byte) begin
         phase_in    = PH_KEYLEN;
         acc_in      = '0;
         cnt_in      = '0;
         left_in     = '0;
         hdr_left_in = '0;
         hdr_cnt_in  = '0;
         err_in      = 1'b0;
      end
   end

   // State update on each stepped byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_KEYLEN;
         acc_ff      <= '0;
         cnt_ff      <= '0;
         left_ff     <= '0;
         hdr_left_ff <= '0;
         hdr_cnt_ff  <= '0;
         err_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         left_ff     <= left_in;
         hdr_left_ff <= hdr_left_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         err_ff      <= err_in;
      end
   end

   // A completed record always coincides with the end of a field.
   assert property (@(posedge clock) disable iff (reset)
      result.record_done |-> result.field_end)
      else $error("record_done without field_end");

   // A null field is only reported on a completed length.
   assert property (@(posedge clock) disable iff (reset)
      result.field_null |-> (result.field_end && result.length_value[63]))
      else $error("field_null without a negative completed length");

   // Errors are raised only while the parser is active.
   assert property (@(posedge clock) disable iff (reset)
      (result.fault_code != ERR_NONE) |-> (result.role != ROLE_IGNORED))
      else $error("error reported on an ignored byte");

   // A stepped last byte re-arms the parser.
   assert property (@(posedge clock) disable iff (reset)
      (step && last_byte) |=> (phase_ff == PH_KEYLEN && !err_ff && cnt_ff == '0))
      else $error("parser not re-armed after the last byte");

endmodule

// File: sv/record_body_varint_parser.sv
// ----------------------------------------------------------------------------
// record_body_varint_parser
// Streaming parser for one record body: zigzag varint lengths, key, value,
// header count and header entries, with each byte tagged by its role.
//
// Usage:
//   The req_ channel carries one payload byte per transfer, req_tlast on the
//   final byte of the payload. The rsp_ channel returns exactly one result
//   per byte, in order: the byte, its role in rsp_tuser, and field, length,
//   header, completion and error information in rsp_tdata.
//   An accepted byte is captured in an input register and then parsed into
//   the result register, which drives rsp_tvalid and the rsp_ payload.
//   One byte per cycle is sustained while the receiver keeps rsp_tready high;
//   the parse state update between the two registers is the only loop.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more byte; further bytes wait on req_tready.
//   Reset empties both registers and puts the parser at the key length.
//   The last byte of every payload re-arms the parser for the next one.
// ----------------------------------------------------------------------------
module record_body_varint_parser #(
   parameter int LEN_BITS         = 32,
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic                           req_tlast,   // last_byte
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] byte_out, [8] field_end, [9] field_null, [73:10] length_value,
   // [105:74] header_number, [106] record_done, [108:107] fault_code, rest 0
   output logic [rvp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [3:0]                     rsp_tuser    // [3:0] role
);
   import rvp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type parse_res;
   logic       out_free;
   logic       step;
   logic       req_xfer;

   // Handshake between the two registers.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parse stage.
   rvp_parser #(
      .LEN_BITS         (LEN_BITS),
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (parse_res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         out_ff <= parse_res;
      end
   end

   // Result packing.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.role;
   assign rsp_tdata  = {3'd0,
                        out_ff.fault_code,
                        out_ff.record_done,
                        out_ff.header_number,
                        out_ff.length_value,
                        out_ff.field_null,
                        out_ff.field_end,
                        out_ff.byte_out};

endmodule

// File: dv/tb_record_body_varint_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_record_body_varint_parser
// Self-checking bench for the record body varint parser. A short directed
// table covers zero, null and oversized lengths, a long varint, truncation
// and trailing bytes. Random records follow, most of them well formed and
// the rest cut short, broken or pure noise. Each returned byte is compared
// field by field against its hand-typed tag or a byte-level parser model.
// Both stream sides idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_record_body_varint_parser;
   import rvp_pkg::*;

   localparam int LEN_BITS         = 32;
   localparam int MAX_VARINT_BYTES = 10;
   localparam int RANDOM_ITEMS     = 1450;
   localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

   // One payload byte of stimulus, optionally with its tag typed in by hand.
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;
      result_type tag;
   } payload_byte_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [3:0]            rsp_tuser;

   payload_byte_type payload_q[$];
   logic [7:0]    rec_q[$];
   result_type    byte_tags_q[$];
   int            tag_mismatches = 0;
   bit            calm           = 1'b0;
   int            tx_mood        = 1;
   int            rx_mood        = 1;
   int            rx_stall_left  = 0;
   result_type    seen;
   result_type    pred_tag;

   // Parser model state.
   logic [3:0]  phase;
   logic [63:0] vacc;
   int          vcount;
   logic [63:0] field_left;
   logic [63:0] hdrs_left;
   logic [63:0] hdr_index;
   bit          err_latched;

   record_body_varint_parser #(
      .LEN_BITS         (LEN_BITS),
      .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   function automatic void clear_parser();
      phase       = ROLE_KEYLEN;
      vacc        = '0;
      vcount      = 0;
      field_left  = '0;
      hdrs_left   = '0;
      hdr_index   = '0;
      err_latched = 1'b0;
   endfunction

   // Data phase that follows a length phase.
   function automatic logic [3:0] field_phase(logic [3:0] len_ph);
      case (len_ph)
         ROLE_KEYLEN:  return ROLE_KEY;
         ROLE_VALLEN:  return ROLE_VALUE;
         ROLE_HKEYLEN: return ROLE_HKEY;
         default:      return ROLE_HVALUE;
      endcase
   endfunction

   // Move past a finished data field; returns 1 when the record is complete.
   function automatic bit close_field(logic [3:0] data_ph);
      case (data_ph)
         ROLE_KEY:   phase = ROLE_VALLEN;
         ROLE_VALUE: phase = ROLE_HDRCOUNT;
         ROLE_HKEY:  phase = ROLE_HVALLEN;
         default: begin
            hdr_index = hdr_index + 64'd1;
            hdrs_left = hdrs_left - 64'd1;
            if (hdrs_left == 0) begin
               phase = ROLE_IGNORED;
               return 1'b1;
            end
            phase = ROLE_HKEYLEN;
         end
      endcase
      return 1'b0;
   endfunction

   // Tags one payload byte and advances the parser state.
   function automatic result_type tag_byte(logic [7:0] b, logic lst);
      result_type  r;
      logic [3:0]  ph;
      logic [63:0] v;
      r          = '0;
      r.byte_out = b;
      r.role     = ROLE_IGNORED;
      if (!err_latched && phase != ROLE_IGNORED) begin
         ph     = phase;
         r.role = ph;
         if (ph >= ROLE_HKEYLEN && ph <= ROLE_HVALUE)
            r.header_number = hdr_index[31:0];
         if (ph == ROLE_KEY || ph == ROLE_VALUE || ph == ROLE_HKEY || ph == ROLE_HVALUE) begin
            field_left = field_left - 64'd1;
            if (field_left == 0) begin
               r.field_end   = 1'b1;
               r.record_done = close_field(ph);
            end
         end else if (vcount >= MAX_VARINT_BYTES) begin
            r.fault_code = ERR_LONG;
            err_latched  = 1'b1;
         end else begin
            // Bits shifted past bit 63 fall off the accumulator.
            vacc   = vacc | (64'(b[6:0]) << (7 * vcount));
            vcount = vcount + 1;
            if (!b[7]) begin
               v              = (vacc >> 1) ^ {64{vacc[0]}};
               vacc           = '0;
               vcount         = 0;
               r.field_end    = 1'b1;
               r.length_value = v;
               if (!v[63] && v > LEN_MAX) begin
                  r.fault_code = ERR_CAPACITY;
                  err_latched  = 1'b1;
               end else if (ph == ROLE_HDRCOUNT) begin
                  // A negative count means no headers at all.
                  if (v[63] || v == 0) begin
                     phase         = ROLE_IGNORED;
                     r.record_done = 1'b1;
                  end else begin
                     hdrs_left = v;
                     hdr_index = '0;
                     phase     = ROLE_HKEYLEN;
                  end
               end else begin
                  // A null header key is reported as an empty one.
                  if (v[63] && ph != ROLE_HKEYLEN)
                     r.field_null = 1'b1;
                  if (v[63] || v == 0) begin
                     r.record_done = close_field(field_phase(ph));
                  end else begin
                     field_left = v;
                     phase      = field_phase(ph);
                  end
               end
            end
         end
         if (lst && r.fault_code == ERR_NONE && phase != ROLE_IGNORED) begin
            r.fault_code = ERR_TRUNC;
            err_latched  = 1'b1;
         end
      end
      if (lst)
         clear_parser();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   task automatic add_row(logic [7:0] d, logic l);
      payload_byte_type p;
      p.data  = d;
      p.last  = l;
      p.typed = 1'b0;
      p.tag   = '0;
      payload_q.insert(payload_q.size(), p);
   endtask

   task automatic add_tagged(logic [7:0] d, logic l, logic [3:0] role, bit fe, bit fn,
                             longint lv, bit done, logic [1:0] ec);
      payload_byte_type p;
      p.data               = d;
      p.last               = l;
      p.typed              = 1'b1;
      p.tag                = '0;
      p.tag.byte_out       = d;
      p.tag.role           = role;
      p.tag.field_end      = fe;
      p.tag.field_null     = fn;
      p.tag.length_value   = lv;
      p.tag.record_done    = done;
      p.tag.fault_code     = ec;
      payload_q.insert(payload_q.size(), p);
   endtask

   task automatic build_directed();
      // Zero key, null value, one header with a null key, trailing byte.
      add_tagged(8'h00, 1'b0, ROLE_KEYLEN, 1'b1, 1'b0, 64'sd0, 1'b0, ERR_NONE);
      add_tagged(8'h01, 1'b0, ROLE_VALLEN, 1'b1, 1'b1, -64'sd1, 1'b0, ERR_NONE);
      add_tagged(8'h02, 1'b0, ROLE_HDRCOUNT, 1'b1, 1'b0, 64'sd1, 1'b0, ERR_NONE);
      add_tagged(8'h01, 1'b0, ROLE_HKEYLEN, 1'b1, 1'b0, -64'sd1, 1'b0, ERR_NONE);
      add_row(8'h02, 1'b0);
      add_row(8'hFF, 1'b0);
      add_tagged(8'hAB, 1'b1, ROLE_IGNORED, 1'b0, 1'b0, 64'sd0, 1'b0, ERR_NONE);
      // One-byte key, empty value, negative header count.
      add_row(8'h02, 1'b0);
      add_row(8'hFF, 1'b0);
      add_row(8'h00, 1'b0);
      add_tagged(8'h03, 1'b1, ROLE_HDRCOUNT, 1'b1, 1'b0, -64'sd2, 1'b1, ERR_NONE);
      // Key length of 2^32, one beyond what the counters hold.
      repeat (4) add_row(8'h80, 1'b0);
      add_tagged(8'h20, 1'b1, ROLE_KEYLEN, 1'b1, 1'b0, 64'sh1_0000_0000, 1'b0,
                 ERR_CAPACITY);
      // Eleven-byte varint.
      repeat (MAX_VARINT_BYTES) add_row(8'hFF, 1'b0);
      add_tagged(8'h7F, 1'b1, ROLE_KEYLEN, 1'b0, 1'b0, 64'sd0, 1'b0, ERR_LONG);
      // Payload that ends right after the key length.
      add_tagged(8'h02, 1'b1, ROLE_KEYLEN, 1'b1, 1'b0, 64'sd1, 1'b0, ERR_TRUNC);
   endtask

   // Emits u as LEB128, stretched by pad redundant continuation bytes.
   task automatic put_varint(logic [63:0] u, int pad);
      logic [7:0] b;
      bit         fin;
      for (int i = 0; i < MAX_VARINT_BYTES; i++) begin
         b   = {1'b0, u[6:0]};
         u   = u >> 7;
         fin = (u == 0 && pad == 0) || i == MAX_VARINT_BYTES - 1;
         if (u == 0 && pad > 0)
            pad--;
         // Junk above bit 63 in the tenth byte must be dropped.
         if (i == MAX_VARINT_BYTES - 1)
            b[6:1] = 6'($urandom);
         if (!fin)
            b[7] = 1'b1;
         rec_q.insert(rec_q.size(), b);
         if (fin)
            break;
      end
   endtask

   task automatic put_field();
      int          pick;
      int          len;
      logic [63:0] u;
      pick = $urandom_range(0, 99);
      len  = 0;
      if (pick < 50) begin
         len = $urandom_range(1, 6);
         u   = 64'(2 * len);
      end else if (pick < 65) begin
         u = '0;
      end else if (pick < 80) begin
         u = 64'(2 * $urandom_range(1, 1000) - 1);
      end else if (pick < 88) begin
         u = {$urandom, $urandom} | 64'd1;
      end else begin
         len = $urandom_range(7, 40);
         u   = 64'(2 * len);
      end
      put_varint(u, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0);
      repeat (len) rec_q.insert(rec_q.size(), 8'($urandom));
   endtask

   task automatic build_record();
      int          pick;
      int          hdrs;
      logic [63:0] u;
      put_field();
      put_field();
      pick = $urandom_range(0, 9);
      hdrs = 0;
      if (pick < 3) begin
         u = '0;
      end else if (pick < 8) begin
         hdrs = $urandom_range(1, 3);
         u    = 64'(2 * hdrs);
      end else if (pick == 8) begin
         u = {$urandom, $urandom} | 64'd1;
      end else begin
         hdrs = $urandom_range(4, 6);
         u    = 64'(2 * hdrs);
      end
      put_varint(u, ($urandom_range(0, 9) == 0) ? 1 : 0);
      repeat (hdrs) begin
         put_field();
         put_field();
      end
      if ($urandom_range(0, 99) < 15)
         repeat ($urandom_range(1, 3)) rec_q.insert(rec_q.size(), 8'($urandom));
   endtask

   task automatic build_random();
      int pick;
      int keep;
      int target;
      target = payload_q.size() + RANDOM_ITEMS;
      while (payload_q.size() < target) begin
         rec_q.delete();
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            build_record();
            // Some records get cut short.
            if (pick >= 70 && rec_q.size() > 1) begin
               keep = $urandom_range(1, rec_q.size() - 1);
               while (rec_q.size() > keep)
                  void'(rec_q.pop_back());
            end
         end else if (pick < 86) begin
            // Overlong varint in the key length, value length or header count.
            repeat ($urandom_range(0, 2)) rec_q.insert(rec_q.size(), 8'h00);
            repeat ($urandom_range(MAX_VARINT_BYTES + 1, MAX_VARINT_BYTES + 3))
               rec_q.insert(rec_q.size(), 8'h80 | 8'($urandom));
            repeat ($urandom_range(0, 3)) rec_q.insert(rec_q.size(), 8'($urandom));
         end else if (pick < 92) begin
            // Lengths at and just beyond the counter capacity.
            repeat ($urandom_range(0, 2)) rec_q.insert(rec_q.size(), 8'h00);
            put_varint((LEN_MAX + 64'($urandom_range(0, 2))) << 1, 0);
            repeat ($urandom_range(0, 4)) rec_q.insert(rec_q.size(), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) rec_q.insert(rec_q.size(), 8'($urandom));
         end
         foreach (rec_q[k])
            add_row(rec_q[k], k == rec_q.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   function automatic string tag_text(result_type r);
      return $sformatf("byte %02h role %0d end %0b null %0b len %0d hdr %0d done %0b err %0d",
                       r.byte_out, r.role, r.field_end, r.field_null, r.length_value,
                       r.header_number, r.record_done, r.fault_code);
   endfunction

   function automatic bit note_mismatch();
      tag_mismatches++;
      return tag_mismatches <= 10;
   endfunction

   function automatic void check_tag(result_type got);
      result_type want;
      bit         bad;
      if (byte_tags_q.size() == 0) begin
         if (note_mismatch())
            $display("%0t: result with no byte pending: %s", $realtime, tag_text(got));
         return;
      end
      want = byte_tags_q.pop_front();
      bad  = got.byte_out !== want.byte_out || got.role !== want.role ||
             got.field_end !== want.field_end || got.field_null !== want.field_null ||
             got.length_value !== want.length_value ||
             got.header_number !== want.header_number ||
             got.record_done !== want.record_done || got.fault_code !== want.fault_code;
      if (bad && note_mismatch()) begin
         $display("%0t: tag mismatch", $realtime);
         $display("   want %s", tag_text(want));
         $display("   got  %s", tag_text(got));
      end
   endfunction

   // Result side: check each transfer, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen               = '0;
         seen.byte_out      = rsp_tdata[7:0];
         seen.field_end     = rsp_tdata[8];
         seen.field_null    = rsp_tdata[9];
         seen.length_value  = rsp_tdata[73:10];
         seen.header_number = rsp_tdata[105:74];
         seen.record_done   = rsp_tdata[106];
         seen.fault_code    = rsp_tdata[108:107];
         seen.role          = rsp_tuser;
         check_tag(seen);
      end
      if ($urandom_range(0, 63) == 0)
         rx_mood = $urandom_range(0, 2);
      if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && rx_mood != 0 && $urandom_range(0, rx_mood == 1 ? 7 : 1) == 0) begin
         rx_stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Input side and end of run
   // ------------------------------------------------------------------------

   initial begin
      clear_parser();
      build_directed();
      build_random();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (payload_q[i]) begin
         if (i >= (payload_q.size() * 85) / 100)
            calm = 1'b1;
         if ($urandom_range(0, 31) == 0)
            tx_mood = $urandom_range(0, 2);
         if (!calm && tx_mood != 0 && $urandom_range(0, tx_mood == 1 ? 7 : 1) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= payload_q[i].data;
         req_tlast  <= payload_q[i].last;
         do @(posedge clock); while (!req_tready);
         pred_tag = tag_byte(payload_q[i].data, payload_q[i].last);
         byte_tags_q.insert(byte_tags_q.size(),
                            payload_q[i].typed ? payload_q[i].tag : pred_tag);
      end
      req_tvalid <= 1'b0;
      while (byte_tags_q.size() != 0)
         @(posedge clock);
      // Run on a while to catch any stray result.
      repeat (20) @(posedge clock);
      if (tag_mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/rvp_pkg.sv
sv/rvp_parser.sv
sv/record_body_varint_parser.sv
dv/tb_record_body_varint_parser.sv
